// ===== rtl/grid_layer_cost_merge_macros.svh =====
// Assertion macros shared by the checker of the grid layer cost merge block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef GRID_LAYER_COST_MERGE_MACROS_SVH
`define GRID_LAYER_COST_MERGE_MACROS_SVH

// Assertion that is switched off while the synchronous reset is low.
`define GLCM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Assertion that also holds while reset is applied.
`define GLCM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== rtl/glcm_pkg.sv =====
// Types, constants and the per-cell merge rule of the grid layer cost merge block.
// Depends on nothing; imported by every module of the block except glcm_ram.
package glcm_pkg;

    localparam int MAX_COLS   = 256;
    localparam int MAX_ROWS   = 256;
    localparam int GRID_CELLS = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W     = $clog2(GRID_CELLS);
    localparam int COST_W     = 8;
    localparam int COORD_W    = 9;
    localparam int REQ_W      = 2;
    localparam int MODE_W     = 2;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_WR_LAYER  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WR_MASTER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RD_MASTER = 2'd2;
    localparam logic [REQ_W-1:0] REQ_MERGE     = 2'd3;

    // Merge rules.
    localparam logic [MODE_W-1:0] MODE_MAX       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OVERWRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRUE_OVWR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ADD       = 2'd3;

    // Register indexes (word address of the configuration port).
    localparam logic [2:0] REG_MERGE_MODE    = 3'd0;
    localparam logic [2:0] REG_LAYER_ENABLED = 3'd1;
    localparam logic [2:0] REG_GRID_COLS     = 3'd2;
    localparam logic [2:0] REG_UNKNOWN_COST  = 3'd3;
    localparam logic [2:0] REG_SATURATE_COST = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]  merge_mode;
        logic               layer_enabled;
        logic [COORD_W-1:0] grid_cols;
        logic [COST_W-1:0]  unknown_cost;
        logic [COST_W-1:0]  saturate_cost;
    } cfg_t;

    // One classified request as it waits between the front and the back.
    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [ADDR_W-1:0]  cell_index;
        logic [COST_W-1:0]  cell_value;
        logic [COORD_W-1:0] min_col;
        logic [COORD_W-1:0] min_row;
        logic [COORD_W-1:0] max_col;
        logic [COORD_W-1:0] max_row;
        logic [ADDR_W-1:0]  row_base;
        logic               noop;
    } qent_t;

    function automatic logic [COST_W-1:0] merge_cell(
        input logic [MODE_W-1:0] mode,
        input logic [COST_W-1:0] unk,
        input logic [COST_W-1:0] sat,
        input logic [COST_W-1:0] master_cost,
        input logic [COST_W-1:0] lay_cost
    );
        logic [COST_W:0]   sum;
        logic [COST_W-1:0] res;
        sum = {1'b0, master_cost} + {1'b0, lay_cost};
        res = master_cost;
        case (mode)
            MODE_MAX: begin
                if (lay_cost == unk) begin
                    res = master_cost;
                end else if (master_cost == unk || master_cost < lay_cost) begin
                    res = lay_cost;
                end
            end
            MODE_OVERWRITE: begin
                if (lay_cost != unk) begin
                    res = lay_cost;
                end
            end
            MODE_TRUE_OVWR: begin
                res = lay_cost;
            end
            MODE_ADD: begin
                if (lay_cost == unk) begin
                    res = master_cost;
                end else if (master_cost == unk) begin
                    res = lay_cost;
                end else if (sum >= {1'b0, sat}) begin
                    res = sat - COST_W'(1);
                end else begin
                    res = sum[COST_W-1:0];
                end
            end
            default: begin
                res = master_cost;
            end
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/glcm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for both cost grids.
module glcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/glcm_cfg.sv =====
// APB-style configuration registers of the grid layer cost merge block.
// Depends on glcm_pkg.
module glcm_cfg
    import glcm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.merge_mode    <= MODE_MAX;
            cfg_reg.layer_enabled <= 1'b1;
            cfg_reg.grid_cols     <= COORD_W'(MAX_COLS);
            cfg_reg.unknown_cost  <= 8'd255;
            cfg_reg.saturate_cost <= 8'd253;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MERGE_MODE:    cfg_reg.merge_mode    <= pwdata[MODE_W-1:0];
                REG_LAYER_ENABLED: cfg_reg.layer_enabled <= pwdata[0];
                REG_GRID_COLS:     cfg_reg.grid_cols     <= pwdata[COORD_W-1:0];
                REG_UNKNOWN_COST:  cfg_reg.unknown_cost  <= pwdata[COST_W-1:0];
                REG_SATURATE_COST: cfg_reg.saturate_cost <= pwdata[COST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_MERGE_MODE:    prdata = PDATA_W'(cfg_reg.merge_mode);
            REG_LAYER_ENABLED: prdata = PDATA_W'(cfg_reg.layer_enabled);
            REG_GRID_COLS:     prdata = PDATA_W'(cfg_reg.grid_cols);
            REG_UNKNOWN_COST:  prdata = PDATA_W'(cfg_reg.unknown_cost);
            REG_SATURATE_COST: prdata = PDATA_W'(cfg_reg.saturate_cost);
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/glcm_front.sv =====
// Front end: accepts requests, classifies merges and queues them for the back end.
// Depends on glcm_pkg.
module glcm_front
    import glcm_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [REQ_W-1:0]   s_req_type,
    input  logic [15:0]        s_cell_index,
    input  logic [COST_W-1:0]  s_cell_value,
    input  logic [COORD_W-1:0] s_min_col,
    input  logic [COORD_W-1:0] s_min_row,
    input  logic [COORD_W-1:0] s_max_col,
    input  logic [COORD_W-1:0] s_max_row,
    output logic               q_valid,
    output qent_t              q_entry,
    input  logic               q_pop
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    qent_t              fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;
    qent_t              push_entry;
    logic [2*COORD_W-1:0] base_full;

    assign s_ready = (count_reg != CNT_W'(FIFO_DEPTH));
    assign q_valid = (count_reg != '0);
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    // Start address of the first window row; later rows step by the stride.
    assign base_full = s_min_row * cfg.grid_cols;

    always_comb begin
        push_entry.req_type   = s_req_type;
        push_entry.cell_index = s_cell_index[ADDR_W-1:0];
        push_entry.cell_value = s_cell_value;
        push_entry.min_col    = s_min_col;
        push_entry.min_row    = s_min_row;
        push_entry.max_col    = s_max_col;
        push_entry.max_row    = s_max_row;
        push_entry.row_base   = base_full[ADDR_W-1:0];
        push_entry.noop       = !cfg.layer_enabled || (s_min_col >= s_max_col) ||
                                (s_min_row >= s_max_row);
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign q_entry = fifo_mem[rd_ptr_reg];

endmodule

// ===== rtl/glcm_back.sv =====
// Back end: executes queued requests against the two grid RAMs and drives results.
// Depends on glcm_pkg and glcm_ram.
module glcm_back
    import glcm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              q_valid,
    input  qent_t             q_entry,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [COST_W-1:0] m_read_cost
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] min_col_reg, min_col_next;
    logic [COORD_W-1:0] max_col_reg, max_col_next;
    logic [COORD_W-1:0] max_row_reg, max_row_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic               rd_flag_reg, rd_flag_next;
    logic               pipe_valid_reg, pipe_valid_next;
    logic [ADDR_W-1:0]  pipe_addr_reg, pipe_addr_next;
    logic               fwd_valid_reg, fwd_valid_next;
    logic [ADDR_W-1:0]  fwd_addr_reg, fwd_addr_next;
    logic [COST_W-1:0]  fwd_data_reg, fwd_data_next;
    logic               m_valid_reg, m_valid_next;
    logic [COST_W-1:0]  read_cost_reg, read_cost_next;

    logic               mst_we, mst_re, lyr_we, lyr_re;
    logic [ADDR_W-1:0]  mst_waddr, mst_raddr, lyr_raddr;
    logic [COST_W-1:0]  mst_wdata, mst_rdata, lyr_rdata;

    logic               slot_free;
    logic [ADDR_W-1:0]  walk_addr;
    logic               col_end, row_end;
    logic [COST_W-1:0]  master_cost, new_cost;

    glcm_ram #(.WIDTH(COST_W), .DEPTH(GRID_CELLS)) u_master_ram (
        .aclk  (aclk),
        .we    (mst_we),
        .waddr (mst_waddr),
        .wdata (mst_wdata),
        .re    (mst_re),
        .raddr (mst_raddr),
        .rdata (mst_rdata)
    );

    glcm_ram #(.WIDTH(COST_W), .DEPTH(GRID_CELLS)) u_layer_ram (
        .aclk  (aclk),
        .we    (lyr_we),
        .waddr (q_entry.cell_index),
        .wdata (q_entry.cell_value),
        .re    (lyr_re),
        .raddr (lyr_raddr),
        .rdata (lyr_rdata)
    );

    assign slot_free = !m_valid_reg || m_ready;
    assign walk_addr = base_reg + ADDR_W'(col_reg);
    assign col_end   = ({1'b0, col_reg} + 1'b1) >= {1'b0, max_col_reg};
    assign row_end   = ({1'b0, row_reg} + 1'b1) >= {1'b0, max_row_reg};

    // The master RAM still returns the old value for a cell written in the
    // previous cycle, so the last merged value is forwarded on a match.
    assign master_cost = (fwd_valid_reg && fwd_addr_reg == pipe_addr_reg) ? fwd_data_reg
                                                                          : mst_rdata;
    assign new_cost = merge_cell(cfg.merge_mode, cfg.unknown_cost, cfg.saturate_cost,
                                 master_cost, lyr_rdata);

    always_comb begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        min_col_next    = min_col_reg;
        max_col_next    = max_col_reg;
        max_row_next    = max_row_reg;
        base_next       = base_reg;
        rd_flag_next    = rd_flag_reg;
        pipe_valid_next = 1'b0;
        pipe_addr_next  = walk_addr;
        fwd_valid_next  = pipe_valid_reg;
        fwd_addr_next   = pipe_addr_reg;
        fwd_data_next   = new_cost;
        m_valid_next    = m_valid_reg && !m_ready;
        read_cost_next  = read_cost_reg;
        q_pop           = 1'b0;
        mst_we          = pipe_valid_reg;
        mst_waddr       = pipe_addr_reg;
        mst_wdata       = new_cost;
        mst_re          = 1'b0;
        mst_raddr       = walk_addr;
        lyr_we          = 1'b0;
        lyr_re          = 1'b0;
        lyr_raddr       = walk_addr;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_entry.req_type)
                        REQ_WR_LAYER: begin
                            if (slot_free) begin
                                q_pop          = 1'b1;
                                lyr_we         = 1'b1;
                                m_valid_next   = 1'b1;
                                read_cost_next = '0;
                            end
                        end
                        REQ_WR_MASTER: begin
                            if (slot_free) begin
                                q_pop          = 1'b1;
                                mst_we         = 1'b1;
                                mst_waddr      = q_entry.cell_index;
                                mst_wdata      = q_entry.cell_value;
                                m_valid_next   = 1'b1;
                                read_cost_next = '0;
                            end
                        end
                        REQ_RD_MASTER: begin
                            q_pop        = 1'b1;
                            mst_re       = 1'b1;
                            mst_raddr    = q_entry.cell_index;
                            rd_flag_next = 1'b1;
                            state_next   = ST_FINISH;
                        end
                        default: begin
                            q_pop        = 1'b1;
                            rd_flag_next = 1'b0;
                            if (q_entry.noop) begin
                                state_next = ST_FINISH;
                            end else begin
                                col_next     = q_entry.min_col;
                                row_next     = q_entry.min_row;
                                min_col_next = q_entry.min_col;
                                max_col_next = q_entry.max_col;
                                max_row_next = q_entry.max_row;
                                base_next    = q_entry.row_base;
                                state_next   = ST_WALK;
                            end
                        end
                    endcase
                end
            end
            ST_WALK: begin
                mst_re          = 1'b1;
                lyr_re          = 1'b1;
                pipe_valid_next = 1'b1;
                if (col_end) begin
                    col_next  = min_col_reg;
                    row_next  = row_reg + 1'b1;
                    base_next = base_reg + ADDR_W'(cfg.grid_cols);
                    if (row_end) begin
                        state_next = ST_DRAIN;
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (slot_free) begin
                    m_valid_next   = 1'b1;
                    read_cost_next = rd_flag_reg ? mst_rdata : '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pipe_valid_reg <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pipe_valid_reg <= pipe_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg       <= col_next;
        row_reg       <= row_next;
        min_col_reg   <= min_col_next;
        max_col_reg   <= max_col_next;
        max_row_reg   <= max_row_next;
        base_reg      <= base_next;
        rd_flag_reg   <= rd_flag_next;
        pipe_addr_reg <= pipe_addr_next;
        fwd_addr_reg  <= fwd_addr_next;
        fwd_data_reg  <= fwd_data_next;
        read_cost_reg <= read_cost_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_read_cost = read_cost_reg;

endmodule

// ===== rtl/grid_layer_cost_merge.sv =====
// Top level of the grid layer cost merge block: configuration port, front end and back end.
// Depends on glcm_pkg, glcm_cfg, glcm_front, glcm_back and glcm_ram.
//
// Usage: requests arrive on the s_ channel (valid/ready). Each request writes a layer
// cell, writes a master cell, reads a master cell, or merges a window of the layer grid
// into the master grid under the rule in merge_mode. Every request gives exactly one
// result on the m_ channel (valid/ready): m_read_cost carries the master cell for a read
// and zero otherwise, and m_done_res is always 1.
// A cell write completes as it leaves the head of the request queue, which needs a free
// output register; cell writes run back to back at one per cycle while results are taken.
// A read holds the back end in the finish state until its result is offered. A merge
// walks its window one cell per cycle through a read-merge-write pipeline on the master
// RAM, then the drain and finish states; an empty window or disabled layer goes to finish.
// A queue of FIFO_DEPTH requests lets the sender keep going while a merge runs or while
// the receiver stalls; s_ready falls only when that queue is full. A result waits in the
// output register until taken; the next cell write waits for it, a read or merge in finish.
// Reset is synchronous and active low; it empties the queue, drops any pending result and
// restores the configuration defaults. The grid RAMs are not cleared: a cell must be
// written before it is read or merged. Configuration may be written only while idle.
module grid_layer_cost_merge
    import glcm_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    // Configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // Request channel.
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [REQ_W-1:0]   s_req_type,
    input  logic [15:0]        s_cell_index,
    input  logic [COST_W-1:0]  s_cell_value,
    input  logic [COORD_W-1:0] s_min_col,
    input  logic [COORD_W-1:0] s_min_row,
    input  logic [COORD_W-1:0] s_max_col,
    input  logic [COORD_W-1:0] s_max_row,
    // Result channel.
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COST_W-1:0]  m_read_cost,
    output logic               m_done_res
);

    cfg_t  cfg;
    logic  q_valid;
    logic  q_pop;
    qent_t q_entry;

    // Registers; user must hold outputs steady whenever requests are in flight (unchecked).
    glcm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The front end decodes each request, computes the first row address of a merge
    // window and flags merges that change nothing, then queues the result.
    glcm_front #(.FIFO_DEPTH(FIFO_DEPTH)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_cell_index (s_cell_index),
        .s_cell_value (s_cell_value),
        .s_min_col    (s_min_col),
        .s_min_row    (s_min_row),
        .s_max_col    (s_max_col),
        .s_max_row    (s_max_row),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .q_pop        (q_pop)
    );

    // The back end owns both grid RAMs and the output register.
    glcm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_cost (m_read_cost)
    );

    // Every result marks a completed request.
    assign m_done_res = 1'b1;

endmodule

// ===== rtl/glcm_checker.sv =====
// Port-level checker of the grid layer cost merge block, bound to its top level.
// Depends on grid_layer_cost_merge_macros.svh and glcm_pkg.
`include "grid_layer_cost_merge_macros.svh"

module glcm_checker
    import glcm_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              pready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [COST_W-1:0] m_read_cost,
    input logic              m_done_res
);

    // A stalled result stays offered.
    `GLCM_ASSERT(a_result_held, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped while stalled")

    // A stalled result keeps its cost.
    `GLCM_ASSERT(a_cost_stable, aclk, aresetn, m_valid && !m_ready |=> $stable(m_read_cost), "result cost changed while stalled")

    // No result is offered right after reset.
    `GLCM_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result offered after reset")

    // Every result reports completion, and the configuration port never waits.
    `GLCM_ASSERT(a_done_and_ready, aclk, aresetn, (m_valid |-> m_done_res) and pready, "missing done flag or pready low")

endmodule

bind grid_layer_cost_merge glcm_checker u_glcm_checker (.*);
